// ===== rtl/core/efr_pkg.sv =====
// ----------------------------------------------------------------------------
// efr_pkg: shared types and constants for the escaped frame receiver
// Byte codes, result kinds, status codes and the CRC-16/ARC byte update.
// ----------------------------------------------------------------------------
package efr_pkg;

    // byte codes on the serial line
    localparam logic [7:0] ESC_CODE  = 8'hF1;
    localparam logic [7:0] TERM_CODE = 8'hF2;

    // reflected CRC-16/ARC polynomial
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // smallest frame that is checked
    localparam int unsigned MIN_FRAME = 3;

    // result kind
    typedef enum logic [0:0] {
        KIND_DATA   = 1'b0,
        KIND_REPORT = 1'b1
    } t_kind;

    // end of frame status
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_CRC_ERR = 2'd1,
        STAT_RUNT    = 2'd2
    } t_status;

    // one byte through the reflected crc, lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/efr_if.sv =====
// ----------------------------------------------------------------------------
// efr_if: valid/ready channels of the escaped frame receiver
// Raw byte channel in, data byte and frame report channel out.
// ----------------------------------------------------------------------------

// raw serial byte channel
interface efr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel: data byte or end of frame report
interface efr_res_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] data_byte;
    logic [6:0] byte_index;
    logic [7:0] frame_length;
    logic [1:0] frame_status;

    modport source (output valid, output out_kind, output data_byte,
                    output byte_index, output frame_length, output frame_status,
                    input ready);
    modport sink   (input valid, input out_kind, input data_byte,
                    input byte_index, input frame_length, input frame_status,
                    output ready);
endinterface

// ===== rtl/core/escaped_frame_receiver_crc16.sv =====
// ----------------------------------------------------------------------------
// escaped_frame_receiver_crc16: byte stuffed frame receiver with crc check
// Unescapes raw bytes, reports stored data bytes and an end of frame status.
// ----------------------------------------------------------------------------
// usage
//   i_rx carries one raw serial byte per request (valid/ready). ESC makes the
//   next byte literal, TERM closes the frame. o_res carries one result per
//   data byte that is stored (kind data, byte and its index in the frame)
//   and one per TERM (kind report, stored length and status).
//   A lone ESC and any byte past FRAME_BYTES give no result.
// output register and throughput
//   a result appears in the output register in the cycle after its byte
//   is taken; one byte is accepted every cycle unless a result waits on
//   a low o_res.ready. Escape flag, counter and crc update are combinational.
// stall
//   while a result waits and o_res.ready is low, i_rx.ready drops; when the
//   sink takes the waiting result, a new byte is taken in the same cycle.
// reset
//   synchronous active low reset clears the escape flag, the count, the crc
//   and the output valid; the block accepts bytes once reset is released.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_crc16
    import efr_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    efr_rx_if.sink          i_rx,
    efr_res_if.source       o_res
);

    localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 1);
    localparam int unsigned EXT_W = CNT_W + 8;

    // frame state
    logic             r_esc;
    logic [CNT_W-1:0] r_count;
    logic [15:0]      r_crc;
    logic             n_esc;
    logic [CNT_W-1:0] n_count;
    logic [15:0]      n_crc;

    // output register
    logic             r_out_valid;
    t_kind            r_kind;
    logic [7:0]       r_data;
    logic [6:0]       r_index;
    logic [7:0]       r_length;
    t_status          r_status;
    logic             n_out_valid;
    t_kind            n_kind;
    logic [7:0]       n_data;
    logic [6:0]       n_index;
    logic [7:0]       n_length;
    t_status          n_status;

    logic             w_accept;
    logic             w_full;
    logic [EXT_W-1:0] w_count_ext;
    logic             w_res_new;

    // handshake: take a byte whenever the output register is free or drains
    assign i_rx.ready  = !r_out_valid || o_res.ready;
    assign w_accept    = i_rx.valid && i_rx.ready;
    assign w_full      = (r_count >= CNT_W'(FRAME_BYTES));
    assign w_count_ext = EXT_W'(r_count);

    // decode the byte against the frame state
    always_comb begin
        n_esc     = r_esc;
        n_count   = r_count;
        n_crc     = r_crc;
        w_res_new = 1'b0;
        n_kind    = KIND_DATA;
        n_data    = i_rx.rx_byte;
        n_index   = w_count_ext[6:0];
        n_length  = 8'h00;
        n_status  = STAT_OK;
        if (w_accept) begin
            if (r_esc) begin
                n_esc = 1'b0;
                if (!w_full) begin
                    w_res_new = 1'b1;
                    n_count   = r_count + CNT_W'(1);
                    n_crc     = crc16_byte(r_crc, i_rx.rx_byte);
                end
            end else if (i_rx.rx_byte == ESC_CODE) begin
                n_esc = 1'b1;
            end else if (i_rx.rx_byte == TERM_CODE) begin
                w_res_new = 1'b1;
                n_kind    = KIND_REPORT;
                n_data    = 8'h00;
                n_index   = 7'h00;
                n_length  = w_count_ext[7:0];
                if (r_count < CNT_W'(MIN_FRAME)) begin
                    n_status = STAT_RUNT;
                end else if (r_crc == 16'h0000) begin
                    n_status = STAT_OK;
                end else begin
                    n_status = STAT_CRC_ERR;
                end
                n_count = '0;
                n_crc   = 16'h0000;
            end else if (!w_full) begin
                w_res_new = 1'b1;
                n_count   = r_count + CNT_W'(1);
                n_crc     = crc16_byte(r_crc, i_rx.rx_byte);
            end
        end
    end

    // output valid follows new results and drains on the sink side
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_res_new) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc       <= 1'b0;
            r_count     <= '0;
            r_crc       <= 16'h0000;
            r_out_valid <= 1'b0;
        end else begin
            r_esc       <= n_esc;
            r_count     <= n_count;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, loaded with each new result
    always_ff @(posedge i_clk) begin
        if (w_res_new) begin
            r_kind   <= n_kind;
            r_data   <= n_data;
            r_index  <= n_index;
            r_length <= n_length;
            r_status <= n_status;
        end
    end

    // result channel
    assign o_res.valid        = r_out_valid;
    assign o_res.out_kind     = r_kind;
    assign o_res.data_byte    = r_data;
    assign o_res.byte_index   = r_index;
    assign o_res.frame_length = r_length;
    assign o_res.frame_status = r_status;

    // checks

    // the stored count never passes the buffer capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FRAME_BYTES))
        else $error("byte count beyond capacity");

    // an unescaped TERM restarts the frame state
    a_term_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_esc && i_rx.rx_byte == TERM_CODE)
        |=> (r_count == '0 && r_crc == 16'h0000 && !r_esc))
        else $error("frame state not cleared after TERM");

    // an unescaped ESC arms the escape flag
    a_esc_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_esc && i_rx.rx_byte == ESC_CODE) |=> r_esc)
        else $error("escape flag not set");

    // data results carry zero length and status fields
    a_data_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_DATA)
        |-> (r_length == 8'h00 && r_status == STAT_OK))
        else $error("data result with report fields set");

endmodule
